// ----- rtl/spae_pkg.sv -----
// Shared types and constants for the step pulse amplitude estimator.
// Used by every module of the block; no dependencies of its own.
package spae_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int CFG_WIDTH        = 16;
    localparam int CFG_ADDR_WIDTH   = 3;
    localparam int OUT_COUNT_WIDTH  = 16;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_BASE_LOW   = 3'd0,
        REG_BASE_HIGH  = 3'd1,
        REG_SIG_LOW    = 3'd2,
        REG_SIG_HIGH   = 3'd3,
        REG_JUMP_LIMIT = 3'd4
    } t_cfg_reg;

    localparam logic signed [CFG_WIDTH-1:0] BASE_LOW_RST   = -16'sd200;
    localparam logic signed [CFG_WIDTH-1:0] BASE_HIGH_RST  = 16'sd200;
    localparam logic signed [CFG_WIDTH-1:0] SIG_LOW_RST    = 16'sd0;
    localparam logic signed [CFG_WIDTH-1:0] SIG_HIGH_RST   = 16'sd0;
    localparam logic        [CFG_WIDTH-1:0] JUMP_LIMIT_RST = 16'd500;

    typedef struct packed {
        logic signed [CFG_WIDTH-1:0] base_low;
        logic signed [CFG_WIDTH-1:0] base_high;
        logic signed [CFG_WIDTH-1:0] sig_low;
        logic signed [CFG_WIDTH-1:0] sig_high;
        logic        [CFG_WIDTH-1:0] jump_limit;
    } t_band_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_DIV_SIG  = 2'd1,
        ST_DIV_BASE = 2'd2,
        ST_DONE     = 2'd3
    } t_seq_state;

endpackage

// ----- rtl/spae_accum.sv -----
// Sample classifier and level accumulator: band check, step detection,
// saturating sums and counts. Depends on spae_pkg.
module spae_accum #(
    parameter int SAMPLE_WIDTH = spae_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = spae_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_accept,
    input  logic signed [SAMPLE_WIDTH-1:0]             i_sample,
    input  spae_pkg::t_band_cfg                        i_cfg,
    output logic                                       o_emit,
    output logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0] o_sig_sum,
    output logic        [COUNT_WIDTH-1:0]              o_sig_cnt,
    output logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0] o_base_sum,
    output logic        [COUNT_WIDTH-1:0]              o_base_cnt
);
    import spae_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int CMP_W = ((SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH) + 1;
    localparam int DIF_W = SAMPLE_WIDTH + 1;
    localparam int LIM_W = (DIF_W > CFG_WIDTH) ? DIF_W : CFG_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] r_prev,      n_prev;
    logic                           r_primed,    n_primed;
    logic                           r_phase,     n_phase;
    logic signed [SUM_W-1:0]        r_base_sum,  n_base_sum;
    logic signed [SUM_W-1:0]        r_sig_sum,   n_sig_sum;
    logic        [COUNT_WIDTH-1:0]  r_base_cnt,  n_base_cnt;
    logic        [COUNT_WIDTH-1:0]  r_sig_cnt,   n_sig_cnt;

    logic signed [CMP_W-1:0] x_cmp;
    logic                    in_band;
    logic signed [DIF_W-1:0] diff;
    logic        [DIF_W-1:0] diff_abs;
    logic                    is_jump;
    logic                    base_full;
    logic                    sig_full;
    logic signed [SUM_W-1:0] x_sum;

    always_comb begin
        x_cmp   = CMP_W'(i_sample);
        in_band = ((x_cmp > CMP_W'(i_cfg.base_low)) && (x_cmp < CMP_W'(i_cfg.base_high)))
               || ((x_cmp > CMP_W'(i_cfg.sig_low))  && (x_cmp < CMP_W'(i_cfg.sig_high)));
        diff     = DIF_W'(i_sample) - DIF_W'(r_prev);
        diff_abs = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
        is_jump  = LIM_W'(diff_abs) >= LIM_W'(i_cfg.jump_limit);
        base_full = &r_base_cnt;
        sig_full  = &r_sig_cnt;
        x_sum     = SUM_W'(i_sample);
    end

    // Only an in-band sample that is a second step produces a result.
    assign o_emit = r_primed && in_band && is_jump && r_phase;

    always_comb begin
        n_prev     = r_prev;
        n_primed   = r_primed;
        n_phase    = r_phase;
        n_base_sum = r_base_sum;
        n_sig_sum  = r_sig_sum;
        n_base_cnt = r_base_cnt;
        n_sig_cnt  = r_sig_cnt;
        if (i_accept) begin
            if (!r_primed) begin
                n_prev   = i_sample;
                n_primed = 1'b1;
            end else if (in_band) begin
                n_prev = i_sample;
                if (!is_jump || !r_phase) begin
                    if (r_phase || is_jump) begin
                        n_phase = 1'b1;
                        if (!sig_full) begin
                            n_sig_sum = r_sig_sum + x_sum;
                            n_sig_cnt = r_sig_cnt + 1'b1;
                        end
                    end else if (!base_full) begin
                        n_base_sum = r_base_sum + x_sum;
                        n_base_cnt = r_base_cnt + 1'b1;
                    end
                end else begin
                    n_phase    = 1'b0;
                    n_base_sum = '0;
                    n_sig_sum  = '0;
                    n_base_cnt = '0;
                    n_sig_cnt  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_primed   <= 1'b0;
            r_phase    <= 1'b0;
            r_base_sum <= '0;
            r_sig_sum  <= '0;
            r_base_cnt <= '0;
            r_sig_cnt  <= '0;
        end else begin
            r_prev     <= n_prev;
            r_primed   <= n_primed;
            r_phase    <= n_phase;
            r_base_sum <= n_base_sum;
            r_sig_sum  <= n_sig_sum;
            r_base_cnt <= n_base_cnt;
            r_sig_cnt  <= n_sig_cnt;
        end
    end

    assign o_sig_sum  = r_sig_sum;
    assign o_sig_cnt  = r_sig_cnt;
    assign o_base_sum = r_base_sum;
    assign o_base_cnt = r_base_cnt;

endmodule

// ----- rtl/spae_divider.sv -----
// Shared radix-2 restoring divider: signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle. Depends on spae_pkg.
module spae_divider #(
    parameter int SAMPLE_WIDTH = spae_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = spae_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0] i_dividend,
    input  logic        [COUNT_WIDTH-1:0]              i_divisor,
    output spae_pkg::t_div_stat                        o_stat,
    output logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0] o_quotient
);
    import spae_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic                   r_neg;
    logic [COUNT_WIDTH-1:0] r_div;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [SUM_W-1:0]       r_quo;

    logic [COUNT_WIDTH:0]   shifted;
    logic [COUNT_WIDTH+1:0] trial;
    logic                   fits;

    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_div};
        fits    = !trial[COUNT_WIDTH+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath holds the dividend magnitude in the quotient register and
    // shifts quotient bits in from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? trial[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_neg ? SUM_W'(-r_quo) : SUM_W'(r_quo);

endmodule

// ----- rtl/step_pulse_amplitude_estimator.sv -----
// Step pulse amplitude estimator top level: configuration registers, sequencer around the
// shared divider, output register. Uses spae_pkg, spae_accum and spae_divider.
// A sample that ends no pulse is absorbed in the idle state; the input stays ready. A
// pulse-ending sample runs two divider passes, signal mean then baseline mean; its result
// then goes to the output register, and the input is ready again once it is loaded,
// after any output stall. Synchronous active-low reset clears state and loads defaults.
module step_pulse_amplitude_estimator #(
    parameter int SAMPLE_WIDTH = spae_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = spae_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_wr_en,
    input  logic [spae_pkg::CFG_ADDR_WIDTH-1:0]    i_cfg_addr,
    input  logic [spae_pkg::CFG_WIDTH-1:0]         i_cfg_wr_data,
    // Input stream. tdata: sample.
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      i_s_tdata,
    // Output stream. tdata: amplitude, baseline_samples, signal_samples.
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [((SAMPLE_WIDTH+33+7)/8)*8-1:0]   o_m_tdata,
    // tuser: no_baseline.
    output logic                                   o_m_tuser
);
    import spae_pkg::*;

    localparam int SUM_W   = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int AMP_W   = SAMPLE_WIDTH + 1;
    localparam int OUT_W   = ((SAMPLE_WIDTH + 33 + 7) / 8) * 8;
    localparam int PAY_W   = AMP_W + 2 * OUT_COUNT_WIDTH;
    localparam int CWIDE_W = (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH : OUT_COUNT_WIDTH;

    // Configuration registers.
    t_band_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_low   <= BASE_LOW_RST;
            r_cfg.base_high  <= BASE_HIGH_RST;
            r_cfg.sig_low    <= SIG_LOW_RST;
            r_cfg.sig_high   <= SIG_HIGH_RST;
            r_cfg.jump_limit <= JUMP_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_BASE_LOW:   r_cfg.base_low   <= i_cfg_wr_data;
                REG_BASE_HIGH:  r_cfg.base_high  <= i_cfg_wr_data;
                REG_SIG_LOW:    r_cfg.sig_low    <= i_cfg_wr_data;
                REG_SIG_HIGH:   r_cfg.sig_high   <= i_cfg_wr_data;
                REG_JUMP_LIMIT: r_cfg.jump_limit <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    t_seq_state r_state, n_state;

    logic                          accept;
    logic                          emit;
    logic signed [SUM_W-1:0]       acc_sig_sum;
    logic        [COUNT_WIDTH-1:0] acc_sig_cnt;
    logic signed [SUM_W-1:0]       acc_base_sum;
    logic        [COUNT_WIDTH-1:0] acc_base_cnt;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    spae_accum #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_sample   (i_s_tdata[SAMPLE_WIDTH-1:0]),
        .i_cfg      (r_cfg),
        .o_emit     (emit),
        .o_sig_sum  (acc_sig_sum),
        .o_sig_cnt  (acc_sig_cnt),
        .o_base_sum (acc_base_sum),
        .o_base_cnt (acc_base_cnt)
    );

    // Snapshot of the finished pulse; the accumulator clears at the same edge.
    logic signed [SUM_W-1:0]        r_base_sum;
    logic        [COUNT_WIDTH-1:0]  r_base_cnt;
    logic        [COUNT_WIDTH-1:0]  r_sig_cnt;
    logic signed [SAMPLE_WIDTH-1:0] r_smean;
    logic signed [SAMPLE_WIDTH-1:0] r_bmean;

    logic                          div_start;
    logic signed [SUM_W-1:0]       div_dividend;
    logic        [COUNT_WIDTH-1:0] div_divisor;
    t_div_stat                     div_stat;
    logic signed [SUM_W-1:0]       div_quotient;

    spae_divider #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quotient)
    );

    logic                 r_out_valid;
    logic [AMP_W-1:0]     r_amp;
    logic [OUT_COUNT_WIDTH-1:0] r_out_bcnt;
    logic [OUT_COUNT_WIDTH-1:0] r_out_scnt;
    logic                 r_out_nobase;
    logic                 out_free;
    logic                 out_load;
    logic [CWIDE_W-1:0]   bcnt_wide;
    logic [CWIDE_W-1:0]   scnt_wide;
    logic signed [AMP_W-1:0] amp_next;

    assign out_free = !r_out_valid || i_m_tready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (accept && emit) n_state = ST_DIV_SIG;
            ST_DIV_SIG:  if (div_stat.done) n_state = ST_DIV_BASE;
            ST_DIV_BASE: if (div_stat.done) n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_base_sum;
        div_divisor  = r_base_cnt;
        out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                div_start    = accept && emit;
                div_dividend = acc_sig_sum;
                div_divisor  = acc_sig_cnt;
            end
            ST_DIV_SIG:  div_start = div_stat.done;
            ST_DIV_BASE: ;
            ST_DONE:     out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept && emit) begin
            r_base_sum <= acc_base_sum;
            r_base_cnt <= acc_base_cnt;
            r_sig_cnt  <= acc_sig_cnt;
        end
        // An empty count gives a mean of zero.
        if (r_state == ST_DIV_SIG && div_stat.done) begin
            r_smean <= (r_sig_cnt == '0) ? '0 : div_quotient[SAMPLE_WIDTH-1:0];
        end
        if (r_state == ST_DIV_BASE && div_stat.done) begin
            r_bmean <= (r_base_cnt == '0) ? '0 : div_quotient[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        amp_next  = AMP_W'(r_smean) - AMP_W'(r_bmean);
        bcnt_wide = CWIDE_W'(r_base_cnt);
        scnt_wide = CWIDE_W'(r_sig_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_amp        <= amp_next;
            r_out_bcnt   <= bcnt_wide[OUT_COUNT_WIDTH-1:0];
            r_out_scnt   <= scnt_wide[OUT_COUNT_WIDTH-1:0];
            r_out_nobase <= (r_base_cnt == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_scnt, r_out_bcnt, r_amp});
    assign o_m_tuser  = r_out_nobase;

    // Keeps the packed payload width tied to the field widths.
    localparam int PAD_W = OUT_W - PAY_W;
    if (PAD_W < 0) begin : g_bad_width
        $error("output payload does not fit tdata");
    end

endmodule

// ----- tb/sv/tb_step_pulse_amplitude_estimator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for step_pulse_amplitude_estimator: streams waveform samples
// through the block and compares every amplitude report with a behavioral predictor.
// Depends on spae_pkg and the RTL of the block.
module tb_step_pulse_amplitude_estimator;
    import spae_pkg::*;

    localparam int     COUNT_FULL    = 65535;
    localparam int     SETTLE_CYCLES = 80;
    localparam int     HOLD_CYCLES   = 600;
    localparam longint CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        logic signed [16:0] amplitude;
        logic        [15:0] baseline_samples;
        logic        [15:0] signal_samples;
        logic               no_baseline;
    } t_amp_report;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    t_cfg_reg             cfg_addr    = REG_BASE_LOW;
    logic [CFG_WIDTH-1:0] cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic [15:0]          s_tdata     = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [55:0]          o_m_tdata;
    logic                 o_m_tuser;

    // Predictor state and its copy of the registers.
    t_band_cfg band_cfg;
    int        prev_uv   = 0;
    bit        primed    = 1'b0;
    bit        in_pulse  = 1'b0;
    longint    base_sum  = 0;
    longint    pulse_sum = 0;
    int        base_cnt  = 0;
    int        pulse_cnt = 0;

    logic [15:0] sample_q[$];
    t_amp_report report_q[$];
    t_amp_report want;

    int     mismatches    = 0;
    int     samples_taken = 0;
    int     reports_seen  = 0;
    int     reg_writes    = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_requests = 0;
    int     holds_served  = 0;
    int     hold_left     = 0;
    longint cycle_count   = 0;

    int prime_seq[8]      = '{-32768, 32767, -200, 200, 199, -199, 0, -1};
    int step_seq[12]      = '{5000, 4990, -7, -8, 5000, 5001, 4999, 25000,
                              -999, -998, -997, 12345};
    int zero_jump_seq[6]  = '{-32768, 32767, -32767, 32766, 0, 0};
    int wide_jump_seq[4]  = '{100, -100, 32766, -32767};

    step_pulse_amplitude_estimator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (s_tdata),      // [15:0] sample
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (o_m_tdata),    // [16:0] amplitude, [32:17] baseline, [48:33] signal
        .o_m_tuser     (o_m_tuser)     // [0] no_baseline
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Applies one accepted sample to the predictor and queues the report it closes.
    function automatic void track_sample(logic signed [15:0] x);
        int          xv, b_lo, b_hi, s_lo, s_hi, jl, diff;
        longint      sig_mean, base_mean, amp;
        t_amp_report rpt;
        xv   = x;
        b_lo = $signed(band_cfg.base_low);
        b_hi = $signed(band_cfg.base_high);
        s_lo = $signed(band_cfg.sig_low);
        s_hi = $signed(band_cfg.sig_high);
        jl   = band_cfg.jump_limit;
        if (!primed) begin
            prev_uv = xv;
            primed  = 1'b1;
            return;
        end
        if (!((xv > b_lo && xv < b_hi) || (xv > s_lo && xv < s_hi)))
            return;
        diff    = (xv > prev_uv) ? xv - prev_uv : prev_uv - xv;
        prev_uv = xv;
        if (diff < jl) begin
            if (in_pulse && pulse_cnt < COUNT_FULL) begin
                pulse_sum += xv;
                pulse_cnt++;
            end else if (!in_pulse && base_cnt < COUNT_FULL) begin
                base_sum += xv;
                base_cnt++;
            end
            return;
        end
        if (!in_pulse) begin
            in_pulse   = 1'b1;
            pulse_sum += xv;
            pulse_cnt++;
            return;
        end
        // Second step: both means truncate toward zero.
        sig_mean  = (pulse_cnt != 0) ? pulse_sum / pulse_cnt : 0;
        base_mean = (base_cnt != 0) ? base_sum / base_cnt : 0;
        amp       = sig_mean - base_mean;
        rpt.amplitude        = amp[16:0];
        rpt.baseline_samples = base_cnt[15:0];
        rpt.signal_samples   = pulse_cnt[15:0];
        rpt.no_baseline      = (base_cnt == 0);
        report_q.push_back(rpt);
        in_pulse  = 1'b0;
        base_sum  = 0;
        pulse_sum = 0;
        base_cnt  = 0;
        pulse_cnt = 0;
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int jitter(int n);
        return int'($urandom_range(2 * n)) - n;
    endfunction

    task automatic push_uv(int v);
        sample_q.push_back(16'(clamp16(v)));
    endtask

    // Now and then a full-scale random value slips in ahead of the intended sample.
    task automatic push_noisy(int v);
        if ($urandom_range(99) < 8)
            sample_q.push_back(16'($urandom));
        push_uv(v);
    endtask

    task automatic queue_pulses(int base_lvl, int sig_lvl, int noise, int n_pulses,
                                int max_len);
        int nb, ns, lvl;
        for (int p = 0; p < n_pulses; p++) begin
            nb  = $urandom_range(max_len, 0);
            ns  = $urandom_range(max_len, 1);
            lvl = sig_lvl + jitter(noise);
            repeat (nb) push_noisy(base_lvl + jitter(noise));
            repeat (ns) push_noisy(lvl + jitter(noise));
            // Occasionally the falling step is missing, which merges two pulses.
            if ($urandom_range(19) != 0)
                push_noisy(base_lvl);
        end
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [15:0] val);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        reg_writes++;
        case (idx)
            REG_BASE_LOW:   band_cfg.base_low   = val;
            REG_BASE_HIGH:  band_cfg.base_high  = val;
            REG_SIG_LOW:    band_cfg.sig_low    = val;
            REG_SIG_HIGH:   band_cfg.sig_high   = val;
            REG_JUMP_LIMIT: band_cfg.jump_limit = val;
            default: ;
        endcase
    endtask

    task automatic write_bands(int bl, int bh, int sl, int sh, int jl);
        write_reg(REG_BASE_LOW, 16'(bl));
        write_reg(REG_BASE_HIGH, 16'(bh));
        write_reg(REG_SIG_LOW, 16'(sl));
        write_reg(REG_SIG_HIGH, 16'(sh));
        write_reg(REG_JUMP_LIMIT, 16'(jl));
        @(negedge i_clk);
    endtask

    // Random bands around a baseline level and a signal level well apart from it.
    task automatic pick_bands(output int base_lvl, output int sig_lvl, output int noise);
        int jl, off;
        jl       = $urandom_range(3000, 300);
        base_lvl = int'($urandom_range(30000)) - 15000;
        off      = $urandom_range(8 * jl, 4 * jl);
        sig_lvl  = (base_lvl >= 0) ? base_lvl - off : base_lvl + off;
        noise    = jl / 3;
        write_bands(base_lvl - 2 * jl, base_lvl + 2 * jl, sig_lvl - 2 * jl,
                    sig_lvl + 2 * jl, jl);
    endtask

    task automatic set_idle(int send_pct, int recv_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Waits until every queued sample is taken and every report has come back.
    task automatic drain();
        do
            @(negedge i_clk);
        while (sample_q.size() != 0 || s_tvalid || report_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic compare_field(string name, logic signed [31:0] want_v,
                                 logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Sample driver: one transfer per handshake, random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                track_sample(s_tdata);
                samples_taken++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Report monitor and receiver back-pressure, including the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                reports_seen++;
                if (report_q.size() == 0) begin
                    $display("%0t ns: report with none expected, expected nothing, actual %h/%b",
                             $time, o_m_tdata, o_m_tuser);
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    compare_field("amplitude", want.amplitude, $signed(o_m_tdata[16:0]));
                    compare_field("baseline_samples", want.baseline_samples,
                                  o_m_tdata[32:17]);
                    compare_field("signal_samples", want.signal_samples, o_m_tdata[48:33]);
                    compare_field("no_baseline", want.no_baseline, o_m_tuser);
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (hold_requests != holds_served) begin
                hold_left    <= HOLD_CYCLES;
                holds_served <= holds_served + 1;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int base_lvl, sig_lvl, noise;
        band_cfg = '{BASE_LOW_RST, BASE_HIGH_RST, SIG_LOW_RST, SIG_HIGH_RST, JUMP_LIMIT_RST};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: the first sample only primes, band edges are exclusive,
        // and the signal band is empty.
        set_idle(33, 74);
        foreach (prime_seq[i]) push_uv(prime_seq[i]);
        drain();

        // Fixed bands: steps in both directions, negative means, zero baseline.
        write_bands(-1000, 1000, 3000, 20000, 1500);
        foreach (step_seq[i]) push_uv(step_seq[i]);
        queue_pulses(0, 10000, 400, 20, 4);
        drain();

        // Random bands, short pulses, and the receiver stalls long enough to back up
        // the sample stream.
        pick_bands(base_lvl, sig_lvl, noise);
        set_idle(74, 33);
        queue_pulses(base_lvl, sig_lvl, noise, 40, 1);
        hold_requests++;
        drain();

        // Extremes: widest baseline band, empty signal band, zero and full jump limit.
        set_idle(0, 0);
        write_bands(-32768, 32767, 32767, -32768, 0);
        foreach (zero_jump_seq[i]) push_uv(zero_jump_seq[i]);
        drain();
        write_reg(REG_JUMP_LIMIT, 16'hFFFF);
        @(negedge i_clk);
        foreach (wide_jump_seq[i]) push_uv(wide_jump_seq[i]);
        drain();

        pick_bands(base_lvl, sig_lvl, noise);
        queue_pulses(base_lvl, sig_lvl, noise, 20, 4);
        drain();

        $display("Checked %0d reports from %0d accepted samples, %0d register writes,",
                 reports_seen, samples_taken, reg_writes);
        $display("across default, random and extreme bands, with output stalls.");
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
